[rtl/hms_pkg.sv]
package hms_pkg;

  // fixed-point format of every matrix element
  localparam int unsigned FRAC = 16;
  localparam logic signed [32:0] ONE = 33'sd65536;
  localparam logic [63:0] LIM_DEN = 64'd10000;
  localparam logic [33:0] NORM_NUM = 34'd655360000;
  localparam logic [33:0] LN2_Q30 = 34'd744261118;

  // configuration register indexes
  localparam logic [7:0] CFG_STATIC_RUN_LIMIT = 8'd0;
  localparam logic [7:0] CFG_NORMAL_SCALE     = 8'd1;
  localparam logic [7:0] CFG_CALM_GAIN        = 8'd2;
  localparam logic [7:0] CFG_DRIFT_GAIN       = 8'd3;

  // element limits in units of 1/10000, row-major
  localparam logic [31:0] EJ_LIM [9] = '{32'd10000, 32'd7000, 32'd500000,
                                         32'd7000, 32'd10000, 32'd500000,
                                         32'd10000, 32'd10000, 32'd10000};
  localparam logic [31:0] ST_LIM [9] = '{32'd10009, 32'd5, 32'd900,
                                         32'd5, 32'd10009, 32'd900,
                                         32'd1, 32'd1, 32'd10000};
  localparam logic [31:0] NORM_LIM [9] = '{32'd10900, 32'd1000, 32'd60000,
                                           32'd1000, 32'd10900, 32'd60000,
                                           32'd100, 32'd100, 32'd10000};

  typedef struct packed {
    logic signed [31:0] meas_00;
    logic signed [31:0] meas_01;
    logic signed [31:0] meas_02;
    logic signed [31:0] meas_10;
    logic signed [31:0] meas_11;
    logic signed [31:0] meas_12;
    logic signed [31:0] meas_20;
    logic signed [31:0] meas_21;
    logic signed [31:0] meas_22;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] corr_00;
    logic signed [31:0] corr_01;
    logic signed [31:0] corr_02;
    logic signed [31:0] corr_10;
    logic signed [31:0] corr_11;
    logic signed [31:0] corr_12;
    logic signed [31:0] corr_20;
    logic signed [31:0] corr_21;
    logic signed [31:0] corr_22;
    logic               ejected;
  } corr_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [31:0] wdata;
  } cfg_t;

  // clamped register values seen by the core
  typedef struct packed {
    logic [7:0]  srl;
    logic [16:0] scale;
    logic [16:0] calm;
    logic [16:0] drift;
  } regs_t;

  // identity element for a row-major index
  function automatic logic signed [32:0] ident(input logic [3:0] idx);
    logic signed [32:0] r;
    r = '0;
    if (idx == 4'd0 || idx == 4'd4 || idx == 4'd8) r = ONE;
    return r;
  endfunction

  // |d| > lim/10000 becomes |d| > floor(lim * 2^16 / 10000)
  function automatic logic [32:0] eject_th(input int unsigned i);
    logic [63:0] v;
    v = ({32'd0, EJ_LIM[i]} << FRAC) / LIM_DEN;
    return v[32:0];
  endfunction

  // |d| < lim/10000 becomes |d| <= floor((lim * 2^16 - 1) / 10000)
  function automatic logic [32:0] still_th(input int unsigned i);
    logic [63:0] v;
    v = (({32'd0, ST_LIM[i]} << FRAC) - 64'd1) / LIM_DEN;
    return v[32:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
    return 4'({row, 1'b0}) + 4'(row) + 4'(col);
  endfunction

endpackage

[rtl/hms_chan_if.sv]
interface hms_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/hms_mul.sv]
module hms_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  // shared signed multiplier, product registered
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[rtl/hms_div.sv]
module hms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  // restoring division, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q, num_q[63]};
    diff   = {1'b0, rem_sh} - {2'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[31:0];
        num_d = {num_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        num_d = {num_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

[rtl/hms_core.sv]
module hms_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  meas_i [9],
  input  hms_pkg::regs_t      regs_i,
  input  logic                ack_i,
  output logic                ready_o,
  output logic                done_o,
  output logic signed [31:0]  corr_o [9],
  output logic                ejected_o
);

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_CHECK     = 5'd1;
  localparam logic [4:0] ST_MM_MUL    = 5'd2;
  localparam logic [4:0] ST_MM_ACC    = 5'd3;
  localparam logic [4:0] ST_SCHK      = 5'd4;
  localparam logic [4:0] ST_AM_A      = 5'd5;
  localparam logic [4:0] ST_AM_B      = 5'd6;
  localparam logic [4:0] ST_AM_C      = 5'd7;
  localparam logic [4:0] ST_ND_N      = 5'd8;
  localparam logic [4:0] ST_ND_D      = 5'd9;
  localparam logic [4:0] ST_DIV_GO    = 5'd10;
  localparam logic [4:0] ST_DIV_WAIT  = 5'd11;
  localparam logic [4:0] ST_BRANCH    = 5'd12;
  localparam logic [4:0] ST_NORM      = 5'd13;
  localparam logic [4:0] ST_SQ_MUL    = 5'd14;
  localparam logic [4:0] ST_SQ_UPD    = 5'd15;
  localparam logic [4:0] ST_LN_MUL    = 5'd16;
  localparam logic [4:0] ST_LN_GET    = 5'd17;
  localparam logic [4:0] ST_SQRT      = 5'd18;
  localparam logic [4:0] ST_FDIV_GO   = 5'd19;
  localparam logic [4:0] ST_FDIV_WAIT = 5'd20;
  localparam logic [4:0] ST_BL_MUL    = 5'd21;
  localparam logic [4:0] ST_BL_WR     = 5'd22;
  localparam logic [4:0] ST_DONE      = 5'd23;

  logic [4:0]         state_q, state_d;
  logic signed [31:0] accum_q [9];
  logic signed [31:0] accum_d [9];
  logic [15:0]        cnt_q, cnt_d;
  logic               ej_q, ej_d;

  logic signed [31:0] meas_q [9];
  logic signed [31:0] meas_d [9];
  logic signed [31:0] p_q [9];
  logic signed [31:0] p_d [9];
  logic signed [65:0] acc_q, acc_d;
  logic signed [67:0] t_q, t_d;
  logic [15:0]        n_q, n_d;
  logic               still_in_q, still_in_d;
  logic [1:0]         i_q, i_d, j_q, j_d, k_q, k_d;
  logic [3:0]         idx_q, idx_d, best_q, best_d;
  logic [63:0]        q_q, q_d;
  logic [63:0]        m_q, m_d;
  logic [5:0]         e_q, e_d;
  logic [15:0]        frac_q, frac_d;
  logic [3:0]         rnd_q, rnd_d;
  logic [37:0]        x_q, x_d, r_q, r_d, bit_q, bit_d;
  logic [16:0]        gain_q, gain_d;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic               div_start;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic [63:0]        div_quo;

  logic [3:0]         rd_idx;
  logic signed [32:0] s_rd;
  logic [32:0]        s_mag;
  logic               in_eject, in_still, s_still;
  logic signed [65:0] acc_sum;
  logic [17:0]        sq_t;
  logic [21:0]        ln_x;
  logic [37:0]        trial;
  logic [15:0]        cnt_inc;

  hms_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  hms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // element read port over the product matrix
  always_comb begin
    rd_idx = idx_q;
    if (state_q == ST_AM_B || state_q == ST_ND_N) rd_idx = best_q;
  end

  assign s_rd  = {p_q[rd_idx][31], p_q[rd_idx]} - hms_pkg::ident(rd_idx);
  assign s_mag = hms_pkg::mag33(s_rd);

  // limit checks on the measurement and on the accumulated deviation
  always_comb begin
    logic signed [32:0] dv;
    logic signed [32:0] sv;
    in_eject = 1'b0;
    in_still = 1'b1;
    s_still  = 1'b1;
    for (int unsigned e = 0; e < 9; e++) begin
      dv = {meas_q[e][31], meas_q[e]} - hms_pkg::ident(4'(e));
      sv = {p_q[e][31], p_q[e]} - hms_pkg::ident(4'(e));
      if (hms_pkg::mag33(dv) > hms_pkg::eject_th(e)) in_eject = 1'b1;
      if (hms_pkg::mag33(dv) > hms_pkg::still_th(e)) in_still = 1'b0;
      if (hms_pkg::mag33(sv) > hms_pkg::still_th(e)) s_still = 1'b0;
    end
  end

  assign acc_sum = acc_q + $signed(prod[65:0]);
  assign sq_t    = prod[33:16];
  assign ln_x    = prod[51:30] + 22'd65536;
  assign trial   = r_q + bit_q;
  assign cnt_inc = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

  // sequencer
  always_comb begin
    state_d    = state_q;
    accum_d    = accum_q;
    cnt_d      = cnt_q;
    ej_d       = ej_q;
    meas_d     = meas_q;
    p_d        = p_q;
    acc_d      = acc_q;
    t_d        = t_q;
    n_d        = n_q;
    still_in_d = still_in_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    idx_d      = idx_q;
    best_d     = best_q;
    q_d        = q_q;
    m_d        = m_q;
    e_d        = e_q;
    frac_d     = frac_q;
    rnd_d      = rnd_q;
    x_d        = x_q;
    r_d        = r_q;
    bit_d      = bit_q;
    gain_d     = gain_q;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          meas_d  = meas_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (in_eject) begin
          for (int unsigned e = 0; e < 9; e++) accum_d[e] = 32'(hms_pkg::ident(4'(e)));
          cnt_d   = '0;
          ej_d    = 1'b1;
          state_d = ST_DONE;
        end else begin
          still_in_d = in_still;
          n_d        = in_still ? cnt_inc : 16'd0;
          i_d        = '0;
          j_d        = '0;
          k_d        = '0;
          acc_d      = '0;
          state_d    = ST_MM_MUL;
        end
      end
      // P = P0 * accum, one product a step
      ST_MM_MUL: begin
        mul_a   = still_in_q ? 34'(hms_pkg::ident(hms_pkg::idx3(i_q, k_q)))
                             : 34'(meas_q[hms_pkg::idx3(i_q, k_q)]);
        mul_b   = 34'(accum_q[hms_pkg::idx3(k_q, j_q)]);
        state_d = ST_MM_ACC;
      end
      ST_MM_ACC: begin
        if (k_q == 2'd2) begin
          p_d[hms_pkg::idx3(i_q, j_q)] = hms_pkg::sat32(acc_sum >>> hms_pkg::FRAC);
          acc_d = '0;
          k_d   = '0;
          if (j_q == 2'd2) begin
            j_d = '0;
            i_d = i_q + 2'd1;
          end else begin
            j_d = j_q + 2'd1;
          end
          state_d = (i_q == 2'd2 && j_q == 2'd2) ? ST_SCHK : ST_MM_MUL;
        end else begin
          acc_d   = acc_sum;
          k_d     = k_q + 2'd1;
          state_d = ST_MM_MUL;
        end
      end
      ST_SCHK: begin
        if (s_still) begin
          for (int unsigned e = 0; e < 9; e++) accum_d[e] = 32'(hms_pkg::ident(4'(e)));
          cnt_d   = n_q;
          ej_d    = 1'b1;
          state_d = ST_DONE;
        end else begin
          ej_d    = 1'b0;
          best_d  = '0;
          idx_d   = 4'd1;
          state_d = ST_AM_A;
        end
      end
      // largest |S|/limit by cross products, the scale cancels
      ST_AM_A: begin
        mul_a   = $signed({1'b0, s_mag});
        mul_b   = $signed({2'b0, hms_pkg::NORM_LIM[best_q]});
        state_d = ST_AM_B;
      end
      ST_AM_B: begin
        t_d     = prod;
        mul_a   = $signed({1'b0, s_mag});
        mul_b   = $signed({2'b0, hms_pkg::NORM_LIM[idx_q]});
        state_d = ST_AM_C;
      end
      ST_AM_C: begin
        if (t_q > prod) best_d = idx_q;
        idx_d   = idx_q + 4'd1;
        state_d = (idx_q == 4'd8) ? ST_ND_N : ST_AM_A;
      end
      ST_ND_N: begin
        mul_a   = $signed({1'b0, s_mag});
        mul_b   = $signed(hms_pkg::NORM_NUM);
        state_d = ST_ND_D;
      end
      ST_ND_D: begin
        t_d     = prod;
        mul_a   = $signed({2'b0, hms_pkg::NORM_LIM[best_q]});
        mul_b   = $signed({17'b0, regs_i.scale});
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        div_num   = t_q[63:0];
        div_den   = prod[31:0];
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          q_d     = div_quo;
          state_d = ST_BRANCH;
        end
      end
      ST_BRANCH: begin
        idx_d = '0;
        if (q_q < 64'd65536) begin
          if ({1'b0, n_q} > 17'(regs_i.srl) + 17'd2) begin
            gain_d  = regs_i.calm;
            state_d = ST_BL_MUL;
          end else begin
            accum_d = p_q;
            cnt_d   = n_q;
            state_d = ST_DONE;
          end
        end else if (cnt_q > 16'(regs_i.srl)) begin
          if (q_q == 64'd65536) begin
            gain_d  = 17'd65536;
            state_d = ST_BL_MUL;
          end else begin
            m_d     = q_q;
            e_d     = '0;
            state_d = ST_NORM;
          end
        end else begin
          n_d     = cnt_inc;
          gain_d  = regs_i.drift;
          state_d = ST_BL_MUL;
        end
      end
      // bring the mantissa into [1, 2)
      ST_NORM: begin
        if (m_q[63:17] != '0) begin
          m_d = m_q >> 1;
          e_d = e_q + 6'd1;
        end else begin
          frac_d  = '0;
          rnd_d   = '0;
          state_d = ST_SQ_MUL;
        end
      end
      // fraction bits of log2 by repeated squaring
      ST_SQ_MUL: begin
        mul_a   = $signed({17'b0, m_q[16:0]});
        mul_b   = $signed({17'b0, m_q[16:0]});
        state_d = ST_SQ_UPD;
      end
      ST_SQ_UPD: begin
        if (sq_t[17]) begin
          m_d    = 64'(sq_t[17:1]);
          frac_d = {frac_q[14:0], 1'b1};
        end else begin
          m_d    = 64'(sq_t);
          frac_d = {frac_q[14:0], 1'b0};
        end
        rnd_d   = rnd_q + 4'd1;
        state_d = (rnd_q == 4'd15) ? ST_LN_MUL : ST_SQ_MUL;
      end
      ST_LN_MUL: begin
        mul_a   = $signed({12'b0, e_q, frac_q});
        mul_b   = $signed(hms_pkg::LN2_Q30);
        state_d = ST_LN_GET;
      end
      ST_LN_GET: begin
        x_d     = {ln_x, 16'b0};
        r_d     = '0;
        bit_d   = 38'd1 << 36;
        state_d = ST_SQRT;
      end
      // integer square root, one result bit a step
      ST_SQRT: begin
        if (x_q >= trial) begin
          x_d = x_q - trial;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 38'd1) state_d = ST_FDIV_GO;
      end
      ST_FDIV_GO: begin
        div_start = 1'b1;
        div_num   = 64'd1 << (2 * hms_pkg::FRAC);
        div_den   = r_q[31:0];
        state_d   = ST_FDIV_WAIT;
      end
      ST_FDIV_WAIT: begin
        if (div_done) begin
          gain_d  = div_quo[16:0];
          state_d = ST_BL_MUL;
        end
      end
      // out = floor(S * gain) + one, saturated
      ST_BL_MUL: begin
        mul_a   = 34'(s_rd);
        mul_b   = $signed({17'b0, gain_q});
        state_d = ST_BL_WR;
      end
      ST_BL_WR: begin
        accum_d[idx_q] = hms_pkg::sat32(($signed(prod[65:0]) >>> hms_pkg::FRAC)
                                        + 66'(hms_pkg::ONE));
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd8) begin
          cnt_d   = n_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_BL_MUL;
        end
      end
      ST_DONE: begin
        if (ack_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int unsigned e = 0; e < 9; e++) accum_q[e] <= 32'(hms_pkg::ident(4'(e)));
      cnt_q   <= '0;
      ej_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
      ej_q    <= ej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q     <= meas_d;
    p_q        <= p_d;
    acc_q      <= acc_d;
    t_q        <= t_d;
    n_q        <= n_d;
    still_in_q <= still_in_d;
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    idx_q      <= idx_d;
    best_q     <= best_d;
    q_q        <= q_d;
    m_q        <= m_d;
    e_q        <= e_d;
    frac_q     <= frac_d;
    rnd_q      <= rnd_d;
    x_q        <= x_d;
    r_q        <= r_d;
    bit_q      <= bit_d;
    gain_q     <= gain_d;
  end

  assign ready_o   = (state_q == ST_IDLE);
  assign done_o    = (state_q == ST_DONE);
  assign corr_o    = accum_q;
  assign ejected_o = ej_q;

endmodule

[rtl/homography_motion_smoother_top.sv]
// Homography motion smoother.
// in_i carries one measured 3x3 homography per video frame (signed Q16.16,
// row-major); out_o gives one correction homography and an ejected flag per
// item. cfg_i writes the four tuning registers by index, always ready; write
// it only while no item is in flight.
// The run time, longer when the damped blend runs, is set by the single
// shared 34x34 multiplier, walked through the 27 products of the matrix
// multiply, and by a one-bit-a-cycle divider used once for the motion
// distance and once more for the damping factor, with a bit-serial
// normalise and square root in between.
// One item is worked on at a time; in_i is not ready until it has finished.
// A finished result moves into an output register, so the next item can be
// taken while the result waits; a stalled receiver holds the core in its
// done state only when that register is still full.
// Reset sets the accumulated transform to the identity, clears the still
// count and loads the register defaults; no item is pending afterwards.
module homography_motion_smoother_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  hms_chan_if.sink   in_i,
  hms_chan_if.source out_o,
  hms_chan_if.sink   cfg_i
);

  logic [7:0]          srl_q;
  logic [16:0]         scale_q, calm_q, drift_q;
  hms_pkg::regs_t      regs;
  logic                core_ready, core_done, core_ej, core_ack;
  logic signed [31:0]  meas [9];
  logic signed [31:0]  corr [9];
  logic                out_valid_q;
  hms_pkg::corr_t      out_data_q;
  hms_pkg::meas_t      in_data;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srl_q   <= 8'd3;
      scale_q <= 17'd32768;
      calm_q  <= 17'd52429;
      drift_q <= 17'd58982;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        hms_pkg::CFG_STATIC_RUN_LIMIT: srl_q   <= cfg_i.data.wdata[7:0];
        hms_pkg::CFG_NORMAL_SCALE:     scale_q <= cfg_i.data.wdata[16:0];
        hms_pkg::CFG_CALM_GAIN:        calm_q  <= cfg_i.data.wdata[16:0];
        hms_pkg::CFG_DRIFT_GAIN:       drift_q <= cfg_i.data.wdata[16:0];
        default: ;
      endcase
    end
  end

  // register clamps
  always_comb begin
    regs.srl   = srl_q;
    regs.scale = (scale_q == 17'd0) ? 17'd1 : (scale_q > 17'd65536 ? 17'd65536 : scale_q);
    regs.calm  = (calm_q > 17'd65536) ? 17'd65536 : calm_q;
    regs.drift = (drift_q > 17'd65536) ? 17'd65536 : drift_q;
  end

  // unpack the input item
  assign in_data = in_i.data;
  assign meas[0] = in_data.meas_00;
  assign meas[1] = in_data.meas_01;
  assign meas[2] = in_data.meas_02;
  assign meas[3] = in_data.meas_10;
  assign meas[4] = in_data.meas_11;
  assign meas[5] = in_data.meas_12;
  assign meas[6] = in_data.meas_20;
  assign meas[7] = in_data.meas_21;
  assign meas[8] = in_data.meas_22;

  assign in_i.ready = core_ready;

  hms_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_i.valid),
    .meas_i    (meas),
    .regs_i    (regs),
    .ack_i     (core_ack),
    .ready_o   (core_ready),
    .done_o    (core_done),
    .corr_o    (corr),
    .ejected_o (core_ej)
  );

  // output register, filled when empty or being drained
  assign core_ack = core_done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_ack) begin
      out_data_q.corr_00 <= corr[0];
      out_data_q.corr_01 <= corr[1];
      out_data_q.corr_02 <= corr[2];
      out_data_q.corr_10 <= corr[3];
      out_data_q.corr_11 <= corr[4];
      out_data_q.corr_12 <= corr[5];
      out_data_q.corr_20 <= corr[6];
      out_data_q.corr_21 <= corr[7];
      out_data_q.corr_22 <= corr[8];
      out_data_q.ejected <= core_ej;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

[test/tb_top.sv]
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned ITEMS_PER_PHASE = 640;

  // expected-correction store and predictor of the smoother
  class smoother_scoreboard;
    longint accum [9];
    int unsigned still_cnt;
    int unsigned run_limit, norm_scale, calm, drift;
    hms_pkg::corr_t expected_q[$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < 9; i++) accum[i] = unit(i);
      still_cnt = 0;
      run_limit = 3;
      norm_scale = 32768;
      calm = 52429;
      drift = 58982;
      mismatches = 0;
    endfunction

    function longint unit(int i);
      return (i % 4 == 0) ? 64'sd65536 : 64'sd0;
    endfunction

    function longint unsigned absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint shift_floor(longint v, int s);
      longint unsigned rnd;
      rnd = (64'd1 << s) - 1;
      if (v >= 0) return longint'(longint'(v) >>> s);
      return -longint'((absval(v) + rnd) >> s);
    endfunction

    function bit beyond_eject(longint d [9]);
      for (int i = 0; i < 9; i++)
        if (absval(d[i]) * 10000 > (longint'(hms_pkg::EJ_LIM[i]) << hms_pkg::FRAC)) return 1;
      return 0;
    endfunction

    function bit is_still(longint d [9]);
      for (int i = 0; i < 9; i++)
        if (!(absval(d[i]) * 10000 < (longint'(hms_pkg::ST_LIM[i]) << hms_pkg::FRAC)))
          return 0;
      return 1;
    endfunction

    function longint unsigned motion_dist(longint d [9], int unsigned sc);
      longint unsigned best, q;
      best = 0;
      for (int i = 0; i < 9; i++) begin
        q = (absval(d[i]) * 10000 * 65536) / (longint'(hms_pkg::NORM_LIM[i]) * sc);
        if (q > best) best = q;
      end
      return best;
    endfunction

    function longint unsigned sqrt_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // 1/sqrt(ln q + 1) in q16
    function longint damp_factor(longint unsigned q);
      int p;
      longint unsigned mant, frac, lg, lnv, y;
      if (q <= 64'd65536) return 65536;
      p = 63;
      while (((q >> p) & 1) == 0) p--;
      mant = (p > hms_pkg::FRAC) ? (q >> (p - hms_pkg::FRAC)) : q;
      frac = 0;
      for (int i = 1; i <= hms_pkg::FRAC; i++) begin
        mant = (mant * mant) >> hms_pkg::FRAC;
        if ((mant >> (hms_pkg::FRAC + 1)) != 0) begin
          mant >>= 1;
          frac |= 64'd1 << (hms_pkg::FRAC - i);
        end
      end
      lg = (longint'(p - hms_pkg::FRAC) << hms_pkg::FRAC) | frac;
      lnv = (lg * 64'd744261118) >> 30;
      y = sqrt_floor((lnv + 65536) << hms_pkg::FRAC);
      return longint'((64'd1 << (2 * hms_pkg::FRAC)) / y);
    endfunction

    function int unsigned bump(int unsigned c);
      return c >= 65535 ? 65535 : c + 1;
    endfunction

    function hms_pkg::corr_t make_corr(longint r [9], bit ej);
      hms_pkg::corr_t c;
      for (int i = 0; i < 9; i++) c[288 - 32 * i -: 32] = r[i][31:0];
      c.ejected = ej;
      return c;
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
        hms_pkg::CFG_STATIC_RUN_LIMIT: run_limit = val[7:0];
        hms_pkg::CFG_NORMAL_SCALE:     norm_scale = val[16:0];
        hms_pkg::CFG_CALM_GAIN:        calm = val[16:0];
        hms_pkg::CFG_DRIFT_GAIN:       drift = val[16:0];
        default: ;
      endcase
    endfunction

    // predict the correction for an accepted measurement
    function void note_input(hms_pkg::meas_t m);
      longint mv [9], d [9], p0 [9], p [9], s [9], res [9], idm [9];
      longint unsigned pos, neg, q;
      longint pr, v, cg, dg, f;
      int unsigned n, sc;
      for (int i = 0; i < 9; i++) begin
        mv[i] = longint'($signed(m[287 - 32 * i -: 32]));
        idm[i] = unit(i);
        d[i] = mv[i] - idm[i];
      end
      if (beyond_eject(d)) begin
        accum = idm;
        still_cnt = 0;
        expected_q.push_back(make_corr(idm, 1'b1));
        return;
      end
      n = 0;
      if (is_still(d)) begin
        n = bump(still_cnt);
        p0 = idm;
      end else begin
        p0 = mv;
      end
      // product with the accumulated transform
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          pos = 0;
          neg = 0;
          for (int k = 0; k < 3; k++) begin
            pr = p0[i * 3 + k] * accum[k * 3 + j];
            if (pr >= 0) pos += pr;
            else neg += absval(pr);
          end
          if (pos >= neg) v = longint'((pos - neg) >> hms_pkg::FRAC);
          else v = -longint'(((neg - pos) + 65535) >> hms_pkg::FRAC);
          p[i * 3 + j] = clip32(v);
        end
      for (int i = 0; i < 9; i++) s[i] = p[i] - idm[i];
      if (is_still(s)) begin
        accum = idm;
        still_cnt = n;
        expected_q.push_back(make_corr(idm, 1'b1));
        return;
      end
      sc = norm_scale < 1 ? 1 : (norm_scale > 65536 ? 65536 : norm_scale);
      cg = calm > 65536 ? 65536 : calm;
      dg = drift > 65536 ? 65536 : drift;
      q = motion_dist(s, sc);
      if (q < 65536) begin
        if (int'(n) - 2 > int'(run_limit)) begin
          for (int i = 0; i < 9; i++) res[i] = clip32(shift_floor(s[i] * cg, 16) + 65536);
        end else begin
          res = p;
        end
      end else if (still_cnt > run_limit) begin
        f = damp_factor(q);
        for (int i = 0; i < 9; i++)
          res[i] = clip32(shift_floor(s[i] * f, hms_pkg::FRAC) + 65536);
      end else begin
        n = bump(still_cnt);
        for (int i = 0; i < 9; i++) res[i] = clip32(shift_floor(s[i] * dg, 16) + 65536);
      end
      accum = res;
      still_cnt = n;
      expected_q.push_back(make_corr(res, 1'b0));
    endfunction

    function void check_result(hms_pkg::corr_t got);
      hms_pkg::corr_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected correction %h", got);
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 9; i++)
        if (got[288 - 32 * i -: 32] !== want[288 - 32 * i -: 32]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("corr_%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                     $signed(want[288 - 32 * i -: 32]), $signed(got[288 - 32 * i -: 32]));
        end
      if (got.ejected !== want.ejected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ejected: expected %0b, got %0b", want.ejected, got.ejected);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hms_chan_if #(.T(hms_pkg::meas_t)) in_if ();
  hms_chan_if #(.T(hms_pkg::corr_t)) out_if ();
  hms_chan_if #(.T(hms_pkg::cfg_t))  cfg_if ();

  homography_motion_smoother_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  smoother_scoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          rx_hold;
  int unsigned quiet_cycles;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver ready with random stalls or a long hold-off
  always @(posedge clk_i) begin
    out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // handshake monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.data.addr, cfg_if.data.wdata);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_frame(hms_pkg::meas_t m);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= m;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{addr: idx, wdata: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int spread(int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  // measurement built from a deviation from the identity
  function automatic hms_pkg::meas_t from_dev(int dg, int off, int tr, int per);
    hms_pkg::meas_t m;
    m.meas_00 = 65536 + spread(dg);
    m.meas_01 = spread(off);
    m.meas_02 = spread(tr);
    m.meas_10 = spread(off);
    m.meas_11 = 65536 + spread(dg);
    m.meas_12 = spread(tr);
    m.meas_20 = spread(per);
    m.meas_21 = spread(per);
    m.meas_22 = 65536 + spread(dg);
    return m;
  endfunction

  function automatic hms_pkg::meas_t random_frame();
    int unsigned k;
    hms_pkg::meas_t m;
    k = $urandom_range(99);
    if (k < 6) begin
      // noise over the whole range
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else if (k < 10) begin
      // one element beyond its ejection limit
      m = from_dev(300, 100, 65536, 50);
      m[287 - 32 * $urandom_range(8) -: 32] = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    end else if (k < 45) begin
      m = from_dev(2, 1, 100, 1);
    end else if (k < 55) begin
      m = 288'(0) | {32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
                     32'sd0, 32'sd0, 32'sd65536};
    end else if (k < 80) begin
      m = from_dev(500, 100, 3 * 65536, 10);
    end else begin
      m = from_dev(20000, 13000, 40 * 65536, 300);
    end
    return m;
  endfunction

  task automatic run_random(int unsigned count);
    hms_pkg::meas_t m;
    for (int unsigned i = 0; i < count; i++) begin
      m = random_frame();
      send_frame(m);
    end
  endtask

  initial begin
    hms_pkg::meas_t m;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    rx_hold = 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct = 47;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, still runs, damped and gained motion
    send_frame({9{32'sh7FFFFFFF}});
    send_frame({9{32'sh80000000}});
    send_frame('0);
    for (int i = 0; i < 6; i++) send_frame(from_dev(0, 0, 0, 0));
    send_frame(from_dev(20000, 13000, 40 * 65536, 300));
    for (int i = 0; i < 6; i++) send_frame(from_dev(1, 0, 50, 0));
    send_frame(from_dev(300, 50, 65536, 5));
    send_frame(from_dev(300, 50, 65536, 5));
    send_frame(from_dev(20000, 13000, 40 * 65536, 300));
    m = from_dev(0, 0, 0, 0);
    m.meas_02 = 32'sd3276800;
    send_frame(m);
    send_frame(from_dev(0, 0, 0, 0));
    drain();

    // phase one: reset values, sender idles less than receiver
    run_random(ITEMS_PER_PHASE);
    drain();
    write_reg(hms_pkg::CFG_STATIC_RUN_LIMIT, 32'd0);
    write_reg(hms_pkg::CFG_NORMAL_SCALE, 32'd1);
    write_reg(hms_pkg::CFG_CALM_GAIN, 32'd0);
    write_reg(hms_pkg::CFG_DRIFT_GAIN, 32'd65536);

    // phase two: roles swapped, with a long receiver hold-off
    tx_idle_pct = 47;
    rx_idle_pct = 34;
    fork
      begin
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      run_random(ITEMS_PER_PHASE / 2);
    join
    drain();
    write_reg(hms_pkg::CFG_STATIC_RUN_LIMIT, 32'd255);
    write_reg(hms_pkg::CFG_NORMAL_SCALE, 32'd65536);
    write_reg(hms_pkg::CFG_CALM_GAIN, 32'd65536);
    write_reg(hms_pkg::CFG_DRIFT_GAIN, 32'd0);
    run_random(ITEMS_PER_PHASE / 2);
    drain();
    write_reg(hms_pkg::CFG_STATIC_RUN_LIMIT, 32'd2);
    write_reg(hms_pkg::CFG_NORMAL_SCALE, 32'h1FFFF);
    write_reg(hms_pkg::CFG_CALM_GAIN, 32'h1FFFF);
    write_reg(hms_pkg::CFG_DRIFT_GAIN, 32'h1FFFF);
    run_random(ITEMS_PER_PHASE / 4);
    drain();
    write_reg(hms_pkg::CFG_STATIC_RUN_LIMIT, $urandom_range(8));
    write_reg(hms_pkg::CFG_NORMAL_SCALE, 32'd0);
    write_reg(hms_pkg::CFG_CALM_GAIN, $urandom_range(65536));
    write_reg(hms_pkg::CFG_DRIFT_GAIN, $urandom_range(65536));

    // phase three: no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(ITEMS_PER_PHASE / 4);
    drain();
    write_reg(hms_pkg::CFG_STATIC_RUN_LIMIT, 32'd3);
    write_reg(hms_pkg::CFG_NORMAL_SCALE, $urandom_range(1, 65536));
    write_reg(hms_pkg::CFG_CALM_GAIN, 32'd52429);
    write_reg(hms_pkg::CFG_DRIFT_GAIN, 32'd58982);
    run_random(ITEMS_PER_PHASE / 2);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
